/* rtl/tun_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_pkg
// Shared constants, types and helpers for the triangle unit normal block.
// ----------------------------------------------------------------------------
package tun_pkg;

  // fraction bits of each normal component
  localparam int NORMAL_FRAC_BITS = 30;

  // coordinate, edge and cross product widths
  localparam int COORD_W  = 32;
  localparam int EDGE_W   = COORD_W + 1;
  localparam int CROSS_W  = 2 * EDGE_W;
  localparam int CMAG_W   = CROSS_W - 1;
  localparam int HPOS_W   = $clog2(CMAG_W);

  // normalized magnitudes land their top bit here
  localparam int NORM_TOP_BIT = 30;
  localparam int MAG_W        = NORM_TOP_BIT + 1;
  localparam int SQ_W         = 2 * MAG_W;
  localparam int SUM_W        = SQ_W + 2;

  // digit recurrence for t = floor(2 * m * 2^F / sqrt(S))
  localparam int NSTEP  = NORMAL_FRAC_BITS + 2;
  localparam int T_W    = NSTEP;
  localparam int QACC_W = T_W + SUM_W;
  localparam int REM_W  = 2 * NORMAL_FRAC_BITS + 70;
  localparam int RSH    = 2 * NORMAL_FRAC_BITS + 2;

  // output width and queue depth
  localparam int OUT_W   = 32;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // one classified triangle handed from front to back
  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [MAG_W-1:0] mag_z;
    logic             neg_x;
    logic             neg_y;
    logic             neg_z;
    logic             degen;
  } norm_item_t;

  // position of the highest set bit (zero when no bit set)
  function automatic logic [HPOS_W-1:0] top_bit(input logic [CMAG_W-1:0] v);
    logic [HPOS_W-1:0] h;
    h = '0;
    for (int i = 0; i < CMAG_W; i++) begin
      if (v[i]) h = HPOS_W'(i);
    end
    return h;
  endfunction

endpackage

/* rtl/tun_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_front
// Accepts triangles, forms edges and cross product, classifies degenerate
// cases and normalizes the product magnitudes to a common top bit.
// ----------------------------------------------------------------------------
module tun_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tun_pkg::COORD_W-1:0]  first_x,
  input  logic signed [tun_pkg::COORD_W-1:0]  first_y,
  input  logic signed [tun_pkg::COORD_W-1:0]  first_z,
  input  logic signed [tun_pkg::COORD_W-1:0]  second_x,
  input  logic signed [tun_pkg::COORD_W-1:0]  second_y,
  input  logic signed [tun_pkg::COORD_W-1:0]  second_z,
  input  logic signed [tun_pkg::COORD_W-1:0]  third_x,
  input  logic signed [tun_pkg::COORD_W-1:0]  third_y,
  input  logic signed [tun_pkg::COORD_W-1:0]  third_z,
  output logic                                push,
  output tun_pkg::norm_item_t                 push_item,
  input  logic                                full
);

  localparam int EW = tun_pkg::EDGE_W;
  localparam int CW = tun_pkg::CROSS_W;
  localparam int MW = tun_pkg::CMAG_W;

  logic [5:0] fv;
  logic       adv;

  logic signed [EW-1:0] ax, ay, az, bx, by, bz;
  logic signed [CW-1:0] p0a, p0b, p1a, p1b, p2a, p2b;
  logic signed [CW-1:0] c0, c1, c2;
  logic [MW-1:0]        m4 [3];
  logic [2:0]           n4;
  logic [MW-1:0]        or4;
  logic [MW-1:0]        m5 [3];
  logic [2:0]           n5;
  logic                 d5;
  logic [tun_pkg::HPOS_W-1:0] h5;
  tun_pkg::norm_item_t  it6;
  logic [MW-1:0]        sh [3];

  // the whole front moves unless its last item cannot enter the queue
  assign adv      = !full || !fv[5];
  assign in_stall = !adv;
  assign push     = fv[5] && !full;
  assign push_item = it6;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (adv) begin
      fv <= {fv[4:0], in_valid};
    end
  end

  // edge vectors from the first vertex
  always_ff @(posedge clk) begin
    if (adv) begin
      ax <= EW'(second_x) - EW'(first_x);
      ay <= EW'(second_y) - EW'(first_y);
      az <= EW'(second_z) - EW'(first_z);
      bx <= EW'(third_x) - EW'(first_x);
      by <= EW'(third_y) - EW'(first_y);
      bz <= EW'(third_z) - EW'(first_z);
    end
  end

  // six partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      p0a <= CW'(ay) * CW'(bz);
      p0b <= CW'(by) * CW'(az);
      p1a <= CW'(az) * CW'(bx);
      p1b <= CW'(ax) * CW'(bz);
      p2a <= CW'(ax) * CW'(by);
      p2b <= CW'(ay) * CW'(bx);
    end
  end

  // cross product components
  always_ff @(posedge clk) begin
    if (adv) begin
      c0 <= p0a - p0b;
      c1 <= p1a - p1b;
      c2 <= p2a - p2b;
    end
  end

  // magnitudes and signs
  always_ff @(posedge clk) begin
    if (adv) begin
      n4[0] <= c0[CW-1];
      n4[1] <= c1[CW-1];
      n4[2] <= c2[CW-1];
      m4[0] <= c0[CW-1] ? MW'(-c0) : MW'(c0);
      m4[1] <= c1[CW-1] ? MW'(-c1) : MW'(c1);
      m4[2] <= c2[CW-1] ? MW'(-c2) : MW'(c2);
    end
  end

  assign or4 = m4[0] | m4[1] | m4[2];

  // leading one search and degenerate check
  always_ff @(posedge clk) begin
    if (adv) begin
      m5 <= m4;
      n5 <= n4;
      d5 <= (or4 == '0);
      h5 <= tun_pkg::top_bit(or4);
    end
  end

  // common shift so the top bit lands on the normalization bit
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (h5 > tun_pkg::HPOS_W'(tun_pkg::NORM_TOP_BIT)) begin
        sh[i] = m5[i] >> (h5 - tun_pkg::HPOS_W'(tun_pkg::NORM_TOP_BIT));
      end else begin
        sh[i] = m5[i] << (tun_pkg::HPOS_W'(tun_pkg::NORM_TOP_BIT) - h5);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it6.mag_x <= sh[0][tun_pkg::MAG_W-1:0];
      it6.mag_y <= sh[1][tun_pkg::MAG_W-1:0];
      it6.mag_z <= sh[2][tun_pkg::MAG_W-1:0];
      it6.neg_x <= n5[0];
      it6.neg_y <= n5[1];
      it6.neg_z <= n5[2];
      it6.degen <= d5;
    end
  end

endmodule

/* rtl/tun_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_fifo
// Short queue of classified triangles between the front and the back.
// ----------------------------------------------------------------------------
module tun_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tun_pkg::norm_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output tun_pkg::norm_item_t pop_item
);

  tun_pkg::norm_item_t            mem [tun_pkg::QDEPTH];
  logic [tun_pkg::QPTR_W-1:0]     wptr;
  logic [tun_pkg::QPTR_W-1:0]     rptr;
  logic [tun_pkg::QCNT_W-1:0]     count;

  assign full     = (count == tun_pkg::QCNT_W'(tun_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/tun_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_back
// Squares and sums the normalized magnitudes, then runs a pipelined
// digit recurrence per component to divide by the length, and rounds.
// ----------------------------------------------------------------------------
module tun_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               empty,
  input  tun_pkg::norm_item_t                pop_item,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tun_pkg::OUT_W-1:0]   normal_x,
  output logic signed [tun_pkg::OUT_W-1:0]   normal_y,
  output logic signed [tun_pkg::OUT_W-1:0]   normal_z,
  output logic                               degenerate
);

  localparam int NS = tun_pkg::NSTEP;
  localparam int RW = tun_pkg::REM_W;
  localparam int QW = tun_pkg::QACC_W;
  localparam int TW = tun_pkg::T_W;
  localparam int SW = tun_pkg::SUM_W;

  logic                   be;
  logic                   v1;
  logic [tun_pkg::SQ_W-1:0] sq1 [3];
  logic [2:0]             n1;
  logic                   d1;

  logic [NS:0]            sv;
  logic [SW-1:0]          s_st [NS+1];
  logic [RW-1:0]          d_st [NS+1][3];
  logic [QW-1:0]          q_st [NS+1][3];
  logic [TW-1:0]          t_st [NS+1][3];
  logic [2:0]             n_st [NS+1];
  logic                   g_st [NS+1];

  logic [TW:0]            rnd [3];

  // everything moves unless a finished result is held
  assign be  = !(out_valid && out_stall);
  assign pop = be && !empty;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      sv        <= '0;
      out_valid <= 1'b0;
    end else if (be) begin
      v1        <= !empty;
      sv        <= {sv[NS-1:0], v1};
      out_valid <= sv[NS];
    end
  end

  // squares of the normalized magnitudes
  always_ff @(posedge clk) begin
    if (be) begin
      sq1[0] <= tun_pkg::SQ_W'(pop_item.mag_x) * tun_pkg::SQ_W'(pop_item.mag_x);
      sq1[1] <= tun_pkg::SQ_W'(pop_item.mag_y) * tun_pkg::SQ_W'(pop_item.mag_y);
      sq1[2] <= tun_pkg::SQ_W'(pop_item.mag_z) * tun_pkg::SQ_W'(pop_item.mag_z);
      n1     <= {pop_item.neg_z, pop_item.neg_y, pop_item.neg_x};
      d1     <= pop_item.degen;
    end
  end

  // squared length and recurrence start values
  always_ff @(posedge clk) begin
    if (be) begin
      s_st[0] <= SW'(sq1[0]) + SW'(sq1[1]) + SW'(sq1[2]);
      for (int j = 0; j < 3; j++) begin
        d_st[0][j] <= RW'(sq1[j]) << tun_pkg::RSH;
        q_st[0][j] <= '0;
        t_st[0][j] <= '0;
      end
      n_st[0] <= n1;
      g_st[0] <= d1;
    end
  end

  // one result bit per stage: keep remainder D and running t*S
  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int BIT = NS - 1 - k;
    logic [RW-1:0] trial [3];

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        trial[j] = (RW'(q_st[k][j]) << (BIT + 1)) + (RW'(s_st[k]) << (2 * BIT));
      end
    end

    always_ff @(posedge clk) begin
      if (be) begin
        s_st[k+1] <= s_st[k];
        n_st[k+1] <= n_st[k];
        g_st[k+1] <= g_st[k];
        for (int j = 0; j < 3; j++) begin
          if (trial[j] <= d_st[k][j]) begin
            d_st[k+1][j] <= d_st[k][j] - trial[j];
            q_st[k+1][j] <= q_st[k][j] + (QW'(s_st[k]) << BIT);
            t_st[k+1][j] <= t_st[k][j] | (TW'(1) << BIT);
          end else begin
            d_st[k+1][j] <= d_st[k][j];
            q_st[k+1][j] <= q_st[k][j];
            t_st[k+1][j] <= t_st[k][j];
          end
        end
      end
    end
  end

  // round half away from zero
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rnd[j] = ((TW + 1)'(t_st[NS][j]) + 1'b1) >> 1;
    end
  end

  // output register with sign and degenerate handling
  always_ff @(posedge clk) begin
    if (be) begin
      degenerate <= g_st[NS];
      if (g_st[NS]) begin
        normal_x <= '0;
        normal_y <= '0;
        normal_z <= '0;
      end else begin
        normal_x <= n_st[NS][0] ? -tun_pkg::OUT_W'(rnd[0]) : tun_pkg::OUT_W'(rnd[0]);
        normal_y <= n_st[NS][1] ? -tun_pkg::OUT_W'(rnd[1]) : tun_pkg::OUT_W'(rnd[1]);
        normal_z <= n_st[NS][2] ? -tun_pkg::OUT_W'(rnd[2]) : tun_pkg::OUT_W'(rnd[2]);
      end
    end
  end

endmodule

/* rtl/triangle_unit_normal_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal_top
// Unit face normal of a triangle given as three Q16.16 vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with nine Q16.16 coordinates.
//   A transfer happens on a rising edge with in_valid high, in_stall low.
//   Output channel: out_valid / out_stall with normal_x/y/z in Q2.30 and
//   a degenerate flag (zero normal when the cross product is zero).
//   Throughput: one triangle per cycle while out_stall is low, set by the
//   fully pipelined front (edges, products, leading-one search, shift) and
//   back (squares, sum, one quotient bit per stage over 32 stages, round).
//   Path from input transfer to output transfer: 6 front stages, the queue
//   and 35 back stages.
//   A 4-entry queue joins front and back; when out_stall holds a result
//   the back freezes, the queue fills, and then in_stall rises.
//   Reset (rst, synchronous) empties every stage and the queue; there is
//   no other state and no configuration.
// ----------------------------------------------------------------------------
module triangle_unit_normal_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [tun_pkg::COORD_W-1:0] first_x,
  input  logic signed [tun_pkg::COORD_W-1:0] first_y,
  input  logic signed [tun_pkg::COORD_W-1:0] first_z,
  input  logic signed [tun_pkg::COORD_W-1:0] second_x,
  input  logic signed [tun_pkg::COORD_W-1:0] second_y,
  input  logic signed [tun_pkg::COORD_W-1:0] second_z,
  input  logic signed [tun_pkg::COORD_W-1:0] third_x,
  input  logic signed [tun_pkg::COORD_W-1:0] third_y,
  input  logic signed [tun_pkg::COORD_W-1:0] third_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tun_pkg::OUT_W-1:0]   normal_x,
  output logic signed [tun_pkg::OUT_W-1:0]   normal_y,
  output logic signed [tun_pkg::OUT_W-1:0]   normal_z,
  output logic                               degenerate
);

  logic                push;
  logic                pop;
  logic                full;
  logic                empty;
  tun_pkg::norm_item_t push_item;
  tun_pkg::norm_item_t pop_item;

  // classification front
  tun_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .first_x   (first_x),
    .first_y   (first_y),
    .first_z   (first_z),
    .second_x  (second_x),
    .second_y  (second_y),
    .second_z  (second_z),
    .third_x   (third_x),
    .third_y   (third_y),
    .third_z   (third_z),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  // decoupling queue
  tun_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .pop_item  (pop_item)
  );

  // normalization back
  tun_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .pop_item   (pop_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .degenerate (degenerate)
  );

endmodule

/* rtl/tun_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_checker
// Port-level checks on the output channel of the unit normal block.
// ----------------------------------------------------------------------------
module tun_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [tun_pkg::OUT_W-1:0] normal_x,
  input logic signed [tun_pkg::OUT_W-1:0] normal_y,
  input logic signed [tun_pkg::OUT_W-1:0] normal_z,
  input logic                             degenerate
);

  // held result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // degenerate results carry a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
    else $error("degenerate result with nonzero normal");

  // a real triangle never yields a zero normal
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> normal_x != 0 || normal_y != 0 || normal_z != 0)
    else $error("zero normal on non-degenerate triangle");

  // nothing leaves right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind triangle_unit_normal_top tun_checker u_tun_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .normal_x   (normal_x),
  .normal_y   (normal_y),
  .normal_z   (normal_z),
  .degenerate (degenerate)
);
